// ===== design/sorted_keyed_quantity_table_assert.svh =====
// Assertion macros shared by the sorted key table modules.
`ifndef SORTED_KEYED_QUANTITY_TABLE_ASSERT_SVH
`define SORTED_KEYED_QUANTITY_TABLE_ASSERT_SVH
// Property that must hold at every clock edge out of reset.
`define SKQT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true at a clock edge out of reset.
`define SKQT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== design/skqt_pkg.sv =====
// Package of types, codes and sizes for the sorted key table.
`timescale 1ns / 1ps
package skqt_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_LIST   = 3'd3;
    localparam logic [2:0] ACT_ERASE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Sources of the output register.
    localparam logic [1:0] OUT_ENTRY   = 2'd0;
    localparam logic [1:0] OUT_ERROR   = 2'd1;
    localparam logic [1:0] OUT_ITEM    = 2'd2;
    localparam logic [1:0] OUT_UPDATED = 2'd3;

    // Read address relative to the pointer.
    localparam logic [1:0] RD_PTR  = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // Sources of the data written at the pointer.
    localparam logic [1:0] WR_SHIFT  = 2'd0;
    localparam logic [1:0] WR_ITEM   = 2'd1;
    localparam logic [1:0] WR_UPDATE = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;      // capture the input item
        logic       ptr_clr;   // pointer to the lowest entry
        logic       ptr_top;   // pointer to the entry count
        logic       ptr_inc;
        logic       ptr_dec;
        logic       pos_save;  // remember the pointer as the insert position
        logic [1:0] rd_sel;
        logic       do_write;  // write at the pointer
        logic [1:0] wr_sel;
        logic       out_load;  // load output register
        logic [1:0] out_sel;
        logic [2:0] out_status;
        logic       out_last;
        logic       cnt_inc;
        logic       cnt_dec;
    } skqt_cmd_t;

    typedef struct packed {
        logic       scan_end;  // pointer == count
        logic       key_less;  // read key below item key
        logic       key_eq;    // read key equals item key
        logic       full;
        logic       empty;
        logic       at_last;   // pointer + 1 == count
        logic       at_pos;    // pointer == saved insert position
        logic       out_free;  // output register may be loaded
        logic [2:0] action;
    } skqt_stat_t;
endpackage

// ===== design/skqt_datapath.sv =====
// Datapath: key and quantity memories, scan pointer, item and output registers.
`timescale 1ns / 1ps
module skqt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           action,
    input  logic signed [31:0]   part_key,
    input  logic signed [31:0]   amount,
    input  skqt_pkg::skqt_cmd_t  cmd,
    output skqt_pkg::skqt_stat_t stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [2:0]           status,
    output logic signed [31:0]   entry_key,
    output logic signed [31:0]   entry_quantity,
    output logic                 last
);
    import skqt_pkg::*;
    `include "sorted_keyed_quantity_table_assert.svh"

    logic [31:0] key_mem [TableDepth];
    logic [31:0] qty_mem [TableDepth];
    logic [31:0] rd_key_reg, rd_qty_reg;
    logic [2:0]  act_reg;
    logic [31:0] key_reg, amt_reg;
    logic [CntW-1:0] ptr_reg, pos_reg, cnt_reg;
    logic [CntW-1:0] rd_ptr;
    logic [IdxW-1:0] raddr, waddr;
    logic [31:0] wkey, wqty, sum_qty;
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [31:0] entry_key_reg, entry_quantity_reg;
    logic        last_reg;

    // A shift step for insert reads the entry below the pointer, for erase
    // the entry above it; writes always go to the pointer.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_ptr = ptr_reg - CntW'(1);
            RD_NEXT: rd_ptr = ptr_reg + CntW'(1);
            default: rd_ptr = ptr_reg;
        endcase
    end

    assign raddr   = rd_ptr[IdxW-1:0];
    assign waddr   = ptr_reg[IdxW-1:0];
    assign sum_qty = rd_qty_reg + amt_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_ITEM:
            begin
                wkey = key_reg;
                wqty = amt_reg;
            end
            WR_UPDATE:
            begin
                wkey = rd_key_reg;
                wqty = sum_qty;
            end
            default:
            begin
                wkey = rd_key_reg;
                wqty = rd_qty_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[raddr];
        rd_qty_reg <= qty_mem[raddr];
        if (cmd.do_write)
        begin
            key_mem[waddr] <= wkey;
            qty_mem[waddr] <= wqty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            key_reg <= '0;
            amt_reg <= '0;
            ptr_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= '0;
            entry_key_reg <= '0;
            entry_quantity_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg <= action;
                key_reg <= part_key;
                amt_reg <= amount;
            end
            if (cmd.ptr_clr)
                ptr_reg <= '0;
            else if (cmd.ptr_top)
                ptr_reg <= cnt_reg;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + CntW'(1);
            else if (cmd.ptr_dec)
                ptr_reg <= ptr_reg - CntW'(1);
            if (cmd.pos_save)
                pos_reg <= ptr_reg;
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CntW'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CntW'(1);
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                status_reg <= cmd.out_status;
                last_reg <= cmd.out_last;
                case (cmd.out_sel)
                    OUT_ERROR:
                    begin
                        entry_key_reg <= (cmd.out_status == ST_EMPTY) ? '0 : key_reg;
                        entry_quantity_reg <= '0;
                    end
                    OUT_ITEM:
                    begin
                        entry_key_reg <= key_reg;
                        entry_quantity_reg <= amt_reg;
                    end
                    OUT_UPDATED:
                    begin
                        entry_key_reg <= rd_key_reg;
                        entry_quantity_reg <= sum_qty;
                    end
                    default:
                    begin
                        entry_key_reg <= rd_key_reg;
                        entry_quantity_reg <= rd_qty_reg;
                    end
                endcase
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_key      = entry_key_reg;
    assign entry_quantity = entry_quantity_reg;
    assign last           = last_reg;

    always_comb
    begin
        stat.scan_end = (ptr_reg == cnt_reg);
        stat.key_less = ($signed(rd_key_reg) < $signed(key_reg));
        stat.key_eq   = (rd_key_reg == key_reg);
        stat.full     = (cnt_reg == CntW'(TableDepth));
        stat.empty    = (cnt_reg == '0);
        stat.at_last  = ((ptr_reg + CntW'(1)) == cnt_reg);
        stat.at_pos   = (ptr_reg == pos_reg);
        stat.out_free = !out_valid_reg || out_ready;
        stat.action   = act_reg;
    end

    `SKQT_ASSERT(a_cnt_bound, cnt_reg <= CntW'(TableDepth), "entry count above depth")
    `SKQT_ASSERT(a_no_overwrite, cmd.out_load |-> stat.out_free, "output overwritten")
    `SKQT_NEVER(a_inc_full, cmd.cnt_inc && stat.full, "insert into full table")
    `SKQT_NEVER(a_dec_empty, cmd.cnt_dec && stat.empty, "erase from empty table")
endmodule

// ===== design/skqt_ctrl.sv =====
// Controller state machine sequencing scan, shift and report steps.
`timescale 1ns / 1ps
module skqt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  skqt_pkg::skqt_stat_t stat,
    output skqt_pkg::skqt_cmd_t  cmd
);
    import skqt_pkg::*;
    `include "sorted_keyed_quantity_table_assert.svh"

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DISP   = 10'b00_0000_0010,
        S_RD     = 10'b00_0000_0100,
        S_CMP    = 10'b00_0000_1000,
        S_INS    = 10'b00_0001_0000,
        S_INS_WR = 10'b00_0010_0000,
        S_ERS    = 10'b00_0100_0000,
        S_ERS_WR = 10'b00_1000_0000,
        S_LRD    = 10'b01_0000_0000,
        S_LPUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   hit;

    assign in_ready = (state_reg == S_IDLE);
    assign hit = !stat.scan_end && stat.key_eq;

    // A scan reads each stored entry in S_RD and compares it in S_CMP.
    // Insert shifts from the top down to the saved position, erase from the
    // hit upward, one entry per read and write pair.
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            S_DISP:
                if (stat.action > ACT_ERASE)
                    state_next = S_IDLE;
                else if (stat.action == ACT_INSERT && stat.full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OUT_ERROR;
                        cmd.out_status = ST_FULL;
                        cmd.out_last = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.action == ACT_LIST && stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OUT_ERROR;
                        cmd.out_status = ST_EMPTY;
                        cmd.out_last = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next = (stat.action == ACT_LIST) ? S_LRD : S_RD;
                end
            S_RD:
                state_next = S_CMP;
            S_CMP:
                if (!stat.scan_end && stat.key_less)
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next = S_RD;
                end
                else if (stat.action == ACT_INSERT)
                begin
                    if (hit)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel = OUT_ERROR;
                            cmd.out_status = ST_EXISTS;
                            cmd.out_last = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.pos_save = 1'b1;
                        cmd.ptr_top = 1'b1;
                        state_next = S_INS;
                    end
                end
                else if (!hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OUT_ERROR;
                        cmd.out_status = ST_NOT_FOUND;
                        cmd.out_last = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_last = 1'b1;
                    cmd.out_sel = OUT_ENTRY;
                    state_next = S_IDLE;
                    if (stat.action == ACT_UPDATE)
                    begin
                        cmd.out_sel = OUT_UPDATED;
                        cmd.do_write = 1'b1;
                        cmd.wr_sel = WR_UPDATE;
                    end
                    else if (stat.action == ACT_ERASE)
                        state_next = S_ERS;
                end
            S_INS:
                if (stat.at_pos)
                begin
                    if (stat.out_free)
                    begin
                        cmd.do_write = 1'b1;
                        cmd.wr_sel = WR_ITEM;
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OUT_ITEM;
                        cmd.out_status = ST_OK;
                        cmd.out_last = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_WR;
                end
            S_INS_WR:
            begin
                cmd.do_write = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.ptr_dec = 1'b1;
                state_next = S_INS;
            end
            S_ERS:
                if (stat.at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_ERS_WR;
                end
            S_ERS_WR:
            begin
                cmd.do_write = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.ptr_inc = 1'b1;
                state_next = S_ERS;
            end
            S_LRD:
                state_next = S_LPUT;
            S_LPUT:
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel = OUT_ENTRY;
                    cmd.out_status = ST_OK;
                    cmd.out_last = stat.at_last;
                    cmd.ptr_inc = 1'b1;
                    state_next = stat.at_last ? S_IDLE : S_LRD;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `SKQT_ASSERT(a_onehot, $onehot(state_reg), "state not one-hot")
    `SKQT_ASSERT(a_load_valid, cmd.load |-> in_valid, "item loaded without valid")
    `SKQT_NEVER(a_cnt_both, cmd.cnt_inc && cmd.cnt_dec, "count up and down")
endmodule

// ===== design/sorted_keyed_quantity_table.sv =====
// Top level of the sorted key and quantity table.
// Each item is one command, and only one item is in work at a time: the
// block takes a new item only in its idle state. An undefined action
// returns to idle with no result, and a list of an empty table or an insert
// into a full table reports an error without a scan. The work for a search,
// an update or a miss grows with the entries below the key, and for an
// insert, an erase or a list with the entry count; a list gives one result
// per stored entry. Any result also waits while the previous one is still
// held in the output register.
`timescale 1ns / 1ps
module sorted_keyed_quantity_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [31:0] part_key,
    input  logic signed [31:0] amount,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] entry_key,
    output logic signed [31:0] entry_quantity,
    output logic               last
);
    import skqt_pkg::*;

    skqt_cmd_t  cmd;
    skqt_stat_t stat;

    skqt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd)
    );

    skqt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .action(action), .part_key(part_key),
        .amount(amount), .cmd(cmd), .stat(stat), .out_ready(out_ready),
        .out_valid(out_valid), .status(status), .entry_key(entry_key),
        .entry_quantity(entry_quantity), .last(last)
    );
endmodule
